// ===== sv/mptp_pkg.sv =====
package mptp_pkg;

    localparam int TOP_LEVEL   = 10;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int LEVELS  = TOP_LEVEL + 1;
    localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;

    localparam logic [7:0] RESET_LIMIT = 8'd4;

    typedef enum logic [2:0] {
        ST_PICKED   = 3'd0,
        ST_NONE     = 3'd1,
        ST_ENQUEUED = 3'd2,
        ST_BAD_PRIO = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_PICK = 2'd1,
        OP_BAD  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ID_BITS-1:0] id;
        logic [LIDX_W-1:0]  lvl;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic [3:0] lvl;
    } t_res;

    // 8-bit task id field -> stored id width (keeps the low ID_BITS bits)
    function automatic logic [ID_BITS-1:0] id_in(input logic [7:0] v);
        logic [ID_BITS+7:0] t;
        t = {{ID_BITS{1'b0}}, v};
        return t[ID_BITS-1:0];
    endfunction

    // stored id -> 8-bit result field
    function automatic logic [7:0] id_out(input logic [ID_BITS-1:0] v);
        logic [ID_BITS+7:0] t;
        t = {8'd0, v};
        return t[7:0];
    endfunction

    function automatic logic [3:0] lvl_out(input logic [LIDX_W-1:0] v);
        logic [LIDX_W+3:0] t;
        t = {4'd0, v};
        return t[3:0];
    endfunction

    function automatic logic [LIDX_W-1:0] lvl_in(input logic [3:0] v);
        logic [LIDX_W+3:0] t;
        t = {{LIDX_W{1'b0}}, v};
        return t[LIDX_W-1:0];
    endfunction

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LIDX_W-1:0] l,
                                                  input logic [QPTR_W-1:0] p);
        return ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

// ===== sv/mptp_front.sv =====
module mptp_front (
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_func,
    input  logic [7:0]           i_task_id,
    input  logic [3:0]           i_priority_req,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output mptp_pkg::t_cmd       o_cmd
);

    // decode: pick, enqueue, or enqueue with out-of-range level
    always_comb begin
        o_cmd.id  = mptp_pkg::id_in(i_task_id);
        o_cmd.lvl = mptp_pkg::lvl_in(i_priority_req);
        if (i_func) begin
            o_cmd.op = mptp_pkg::OP_PICK;
        end else if (i_priority_req > 4'(mptp_pkg::TOP_LEVEL)) begin
            o_cmd.op = mptp_pkg::OP_BAD;
        end else begin
            o_cmd.op = mptp_pkg::OP_ENQ;
        end
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

// ===== sv/mptp_cmdq.sv =====
module mptp_cmdq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mptp_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    output mptp_pkg::t_cmd       o_cmd,
    input  logic                 i_pop
);

    // two-entry command queue
    mptp_pkg::t_cmd r_ent [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== sv/mptp_back.sv =====
module mptp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_cmd_valid,
    input  mptp_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_empty,
    output mptp_pkg::t_res       o_res,
    input  logic                 i_pop
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                        r_state;
    logic [7:0]                    r_limit;
    logic [mptp_pkg::QPTR_W-1:0]   r_head   [mptp_pkg::LEVELS];
    logic [mptp_pkg::QPTR_W-1:0]   r_tail   [mptp_pkg::LEVELS];
    logic [mptp_pkg::CNT_W-1:0]    r_fill   [mptp_pkg::LEVELS];
    logic [7:0]                    r_served [mptp_pkg::LEVELS];
    logic [mptp_pkg::LIDX_W-1:0]   r_lvl;

    logic [mptp_pkg::ID_BITS-1:0]  r_mem [mptp_pkg::MEM_DEPTH];
    logic [mptp_pkg::ID_BITS-1:0]  r_rd_data;

    mptp_pkg::t_res                r_ob [2];
    logic                          r_ob_wp;
    logic                          r_ob_rp;
    logic [1:0]                    r_ob_cnt;

    logic [mptp_pkg::LEVELS-1:0]   elig;
    logic                          found;
    logic [mptp_pkg::LIDX_W-1:0]   sel;
    logic                          go;
    logic                          lvl_full;
    logic                          mem_we;
    logic                          mem_re;
    logic                          res_push;
    mptp_pkg::t_res                res_data;
    logic                          ob_pop;

    assign go        = (r_state == S_IDLE) && i_cmd_valid && (r_ob_cnt != 2'd2);
    assign o_cmd_pop = go;
    assign lvl_full  = (r_fill[i_cmd.lvl] == mptp_pkg::CNT_W'(mptp_pkg::QUEUE_DEPTH));
    assign mem_we    = go && (i_cmd.op == mptp_pkg::OP_ENQ) && !lvl_full;
    assign mem_re    = go && (i_cmd.op == mptp_pkg::OP_PICK) && found;

    // eligibility and lowest-numbered eligible level
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int l = 0; l < mptp_pkg::LEVELS; l++) begin
            elig[l] = (r_fill[l] != '0) && (r_served[l] < r_limit);
        end
        for (int l = mptp_pkg::LEVELS - 1; l >= 0; l--) begin
            if (elig[l]) begin
                found = 1'b1;
                sel   = mptp_pkg::LIDX_W'(l);
            end
        end
    end

    // result generation
    always_comb begin
        res_push        = 1'b0;
        res_data.status = mptp_pkg::ST_NONE;
        res_data.id     = 8'd0;
        res_data.lvl    = 4'd0;
        case (r_state)
            S_IDLE: begin
                if (go) begin
                    case (i_cmd.op)
                        mptp_pkg::OP_ENQ: begin
                            res_push        = 1'b1;
                            res_data.status = lvl_full ? mptp_pkg::ST_FULL
                                                       : mptp_pkg::ST_ENQUEUED;
                        end
                        mptp_pkg::OP_PICK: begin
                            if (!found) begin
                                res_push        = 1'b1;
                                res_data.status = mptp_pkg::ST_NONE;
                            end
                        end
                        default: begin
                            res_push        = 1'b1;
                            res_data.status = mptp_pkg::ST_BAD_PRIO;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_push        = 1'b1;
                res_data.status = mptp_pkg::ST_PICKED;
                res_data.id     = mptp_pkg::id_out(r_rd_data);
                res_data.lvl    = mptp_pkg::lvl_out(r_lvl);
            end
            default: begin
                res_push = 1'b0;
            end
        endcase
    end

    // id store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mptp_pkg::addr_of(i_cmd.lvl, r_tail[i_cmd.lvl])] <= i_cmd.id;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mptp_pkg::addr_of(sel, r_head[sel])];
        end
    end

    // sequencer and per-level bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= mptp_pkg::RESET_LIMIT;
            for (int l = 0; l < mptp_pkg::LEVELS; l++) begin
                r_head[l]   <= '0;
                r_tail[l]   <= '0;
                r_fill[l]   <= '0;
                r_served[l] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (go) begin
                        case (i_cmd.op)
                            mptp_pkg::OP_ENQ: begin
                                if (!lvl_full) begin
                                    r_tail[i_cmd.lvl] <= mptp_pkg::ptr_inc(r_tail[i_cmd.lvl]);
                                    r_fill[i_cmd.lvl] <= r_fill[i_cmd.lvl] + 1'b1;
                                end
                            end
                            mptp_pkg::OP_PICK: begin
                                if (found) begin
                                    r_head[sel]   <= mptp_pkg::ptr_inc(r_head[sel]);
                                    r_fill[sel]   <= r_fill[sel] - 1'b1;
                                    r_served[sel] <= r_served[sel] + 8'd1;
                                    if (sel != '0) begin
                                        r_served[0] <= '0;
                                    end
                                    r_lvl   <= sel;
                                    r_state <= S_READ;
                                end else begin
                                    for (int l = 0; l < mptp_pkg::LEVELS; l++) begin
                                        r_served[l] <= '0;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // two-entry result buffer
    assign o_empty = (r_ob_cnt == 2'd0);
    assign o_res   = r_ob[r_ob_rp];
    assign ob_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_ob[r_ob_wp] <= res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            if (res_push) begin
                r_ob_wp <= ~r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= ~r_ob_rp;
            end
            r_ob_cnt <= r_ob_cnt + {1'b0, res_push} - {1'b0, ob_pop};
        end
    end

endmodule

// ===== sv/multilevel_priority_task_picker_core.sv =====
// Multilevel priority task picker. Keeps one FIFO of task ids per level
// (0 highest, up to TOP_LEVEL) plus a served counter per level. An item
// with i_func low enqueues i_task_id on level i_priority_req; an item with
// i_func high picks the head of the lowest-numbered non-empty level whose
// counter is below serve_limit. Exactly one result item comes out per input
// item, in order. Input is taken whenever full is low; results wait in a
// two-entry buffer until popped. The front decodes in the accept cycle into
// a two-entry command queue; the back handles an enqueue, drop or empty
// pick in its idle state, a successful pick in its idle state and then in
// its read state for a registered read of the shared id store. serve_limit
// (i_cfg_data under i_cfg_we) resets to 4 and should only be written idle.
module multilevel_priority_task_picker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_task_id,
    input  logic [3:0]  i_priority_req,
    // result item channel
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_picked_id,
    output logic [3:0]  o_picked_level,
    // serve_limit write
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data
);

    mptp_pkg::t_cmd front_cmd;
    mptp_pkg::t_cmd back_cmd;
    mptp_pkg::t_res res;
    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;

    // decode and classify
    mptp_front u_front (
        .i_push         (push),
        .o_full         (full),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_cmd          (front_cmd)
    );

    // decouples front acceptance from back execution
    mptp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd),
        .i_pop   (q_pop)
    );

    // FIFO bookkeeping, id store, pick search, result buffer
    mptp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    assign o_status       = res.status;
    assign o_picked_id    = res.id;
    assign o_picked_level = res.lvl;

endmodule

// ===== sv/mptp_chk.sv =====
module mptp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic [7:0]  o_picked_id,
    input logic [3:0]  o_picked_level
);

    // reset leaves no result and room for input
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // only defined status codes come out
    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= mptp_pkg::ST_FULL))
        else $error("undefined status code");

    // id and level are zero unless a task was picked
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != mptp_pkg::ST_PICKED)
            |-> (o_picked_id == 8'd0 && o_picked_level == 4'd0))
        else $error("nonzero payload on non-pick result");

    // picked level never above the top level
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == mptp_pkg::ST_PICKED)
            |-> (o_picked_level <= 4'(mptp_pkg::TOP_LEVEL)))
        else $error("picked level out of range");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_picked_id)
                              && $stable(o_picked_level)))
        else $error("waiting result changed");

endmodule

bind multilevel_priority_task_picker_core mptp_chk u_mptp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_status       (o_status),
    .o_picked_id    (o_picked_id),
    .o_picked_level (o_picked_level)
);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // func field codes of an input item
    localparam logic FUNC_ENQ  = 1'b0;
    localparam logic FUNC_PICK = 1'b1;

    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 218;  // ~1525 random items after the table
    localparam int MIX_BLOCK       = 24;   // items per enqueue/pick mix choice
    localparam int DRAIN_TAIL      = 8;    // back end takes longest on a successful pick, with its id store read
    localparam int HOLD_AT         = 300;  // results taken before the long stall
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000; // well above the long stall
    localparam int PRINT_CAP       = 100;

    // receiver stall patterns
    typedef enum int unsigned {
        TAKE_ALL,
        TAKE_HALF,
        TAKE_QUARTER,
        TAKE_SQUARE
    } t_take_mode;

    // one row of the directed table; fixed rows carry the result typed in
    typedef struct {
        logic           func;
        logic [7:0]     id;
        logic [3:0]     prio;
        bit             fixed;
        mptp_pkg::t_res want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       i_func = FUNC_ENQ;
    logic [7:0] i_task_id = 8'h00;
    logic [3:0] i_priority_req = 4'h0;
    logic       empty;
    logic       pop = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_picked_id;
    logic [3:0] o_picked_level;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;

    // travels with the item on the input port, never seen by the block
    bit             item_fixed = 1'b0;
    mptp_pkg::t_res item_want  = '{status: mptp_pkg::ST_NONE, id: 8'h00, lvl: 4'h0};

    // scheduler mirror: per-level id rings, occupancy and served counters
    logic [mptp_pkg::ID_BITS-1:0] slot_ids [mptp_pkg::LEVELS][mptp_pkg::QUEUE_DEPTH];
    logic [mptp_pkg::QPTR_W-1:0]  rd_pos   [mptp_pkg::LEVELS] = '{default: '0};
    logic [mptp_pkg::QPTR_W-1:0]  wr_pos   [mptp_pkg::LEVELS] = '{default: '0};
    logic [mptp_pkg::CNT_W-1:0]   used     [mptp_pkg::LEVELS] = '{default: '0};
    logic [7:0]                   served   [mptp_pkg::LEVELS] = '{default: '0};
    logic [7:0]                   limit_now = mptp_pkg::RESET_LIMIT;

    mptp_pkg::t_res awaited_results[$];
    t_stim_row      stim_rows[$];
    int unsigned    results_seen = 0;
    int unsigned    error_count  = 0;
    int unsigned    idle_run     = 0;

    multilevel_priority_task_picker_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_picked_id    (o_picked_id),
        .o_picked_level (o_picked_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the one result an accepted item causes and advances the mirror.
    function automatic mptp_pkg::t_res next_outcome(input logic func, input logic [7:0] id,
                                                    input logic [3:0] prio);
        mptp_pkg::t_res r;
        bit             found;
        r = '{status: mptp_pkg::ST_NONE, id: 8'h00, lvl: 4'h0};
        found = 1'b0;
        if (func == FUNC_ENQ) begin
            if (prio > mptp_pkg::TOP_LEVEL) begin
                r.status = mptp_pkg::ST_BAD_PRIO;    // out-of-range level, nothing stored
            end else if (used[prio] >= mptp_pkg::QUEUE_DEPTH) begin
                r.status = mptp_pkg::ST_FULL;        // level ring full, nothing stored
            end else begin
                slot_ids[prio][wr_pos[prio]] = mptp_pkg::ID_BITS'(id);
                wr_pos[prio] = (wr_pos[prio] == mptp_pkg::QPTR_W'(mptp_pkg::QUEUE_DEPTH - 1))
                             ? '0 : wr_pos[prio] + 1'b1;
                used[prio] = used[prio] + 1'b1;
                r.status = mptp_pkg::ST_ENQUEUED;
            end
        end else begin
            // lowest-numbered level with work and budget left wins
            for (int lv = 0; lv < mptp_pkg::LEVELS; lv++) begin
                if (!found && used[lv] != 0 && served[lv] < limit_now) begin
                    found    = 1'b1;
                    r.status = mptp_pkg::ST_PICKED;
                    r.id     = 8'(slot_ids[lv][rd_pos[lv]]);
                    r.lvl    = 4'(lv);
                    rd_pos[lv] = (rd_pos[lv] == mptp_pkg::QPTR_W'(mptp_pkg::QUEUE_DEPTH - 1))
                               ? '0 : rd_pos[lv] + 1'b1;
                    used[lv]   = used[lv] - 1'b1;
                    served[lv] = served[lv] + 1'b1;
                    if (lv != 0) begin
                        served[0] = 8'h00;
                    end
                end
            end
            if (!found) begin
                // nothing eligible: every budget starts over
                for (int lv = 0; lv < mptp_pkg::LEVELS; lv++) begin
                    served[lv] = 8'h00;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < PRINT_CAP) begin
            $display("MISMATCH at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
        end
        error_count++;
    endtask

    // Sample both handshakes at the rising edge; the block updates by NBA so
    // everything read here is the pre-edge value. Also runs the watchdog.
    always @(posedge i_clk) begin : scoreboard
        mptp_pkg::t_res want;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n && push && !full) begin
            want = next_outcome(i_func, i_task_id, i_priority_req);
            if (item_fixed) begin
                want = item_want;
            end
            awaited_results.push_back(want);
            moved = 1'b1;
        end
        if (i_rst_n && pop && !empty) begin
            moved = 1'b1;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", o_status, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_picked_id !== want.id) begin
                    report_mismatch("picked_id", o_picked_id, want.id);
                end
                if (o_picked_level !== want.lvl) begin
                    report_mismatch("picked_level", o_picked_level, want.lvl);
                end
            end
        end
        if (moved || !i_rst_n) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", idle_run);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: switches among random take patterns, and once, after
    // HOLD_AT results, stops taking for a long stretch so the block backs up.
    initial begin : result_taker
        t_take_mode  mode;
        int unsigned mode_left;
        int unsigned tick;
        bit          hold_done;
        mode      = TAKE_ALL;
        mode_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_take_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            tick++;
            case (mode)
                TAKE_ALL: begin
                    pop <= 1'b1;
                end
                TAKE_HALF: begin
                    pop <= ($urandom_range(0, 1) == 1);
                end
                TAKE_QUARTER: begin
                    pop <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    pop <= ((tick % 6) < 3);
                end
            endcase
        end
    end

    // Present one item at the falling edge and hold it until accepted.
    task automatic offer_item(input logic f, input logic [7:0] id, input logic [3:0] p,
                              input bit fx, input mptp_pkg::t_res w);
        @(negedge i_clk);
        push           <= 1'b1;
        i_func         <= f;
        i_task_id      <= id;
        i_priority_req <= p;
        item_fixed     <= fx;
        item_want      <= w;
        do begin
            @(posedge i_clk);
        end while (full);
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Stop sending and wait until every awaited result is back.
    task automatic wait_drained();
        idle_cycles(1);
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // serve_limit write; only called with the block idle
    task automatic write_limit(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_now = v;
    endtask

    function automatic void add_row(input logic f, input logic [7:0] id,
                                    input logic [3:0] p, input bit fx,
                                    input mptp_pkg::t_status st, input logic [7:0] wid,
                                    input logic [3:0] wl);
        t_stim_row row;
        row.func  = f;
        row.id    = id;
        row.prio  = p;
        row.fixed = fx;
        row.want  = '{status: st, id: wid, lvl: wl};
        stim_rows.push_back(row);
    endfunction

    initial begin : stimulus
        logic [7:0]     phase_limits [N_PHASES];
        logic           f;
        logic [7:0]     id;
        logic [3:0]     p;
        int unsigned    enq_pct;
        int unsigned    burst_left;
        int unsigned    pick;
        mptp_pkg::t_res no_want;

        no_want    = '{status: mptp_pkg::ST_NONE, id: 8'h00, lvl: 4'h0};
        burst_left = 0;
        enq_pct    = 50;

        // Limits per random phase: min, max, lowered from max to min while
        // counters may sit high, zero (nothing ever eligible), and a few others.
        phase_limits = '{8'd1, 8'd255, 8'd1, 8'd0, 8'd2, 8'd0, 8'd128};
        phase_limits[5] = 8'($urandom_range(3, 254));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset limit of 4.
        // pick with every ring empty after reset
        add_row(FUNC_PICK, 8'h00, 4'h0, 1'b1, mptp_pkg::ST_NONE, 8'h00, 4'h0);
        // extremes of id and of the legal levels
        add_row(FUNC_ENQ, 8'hFF, 4'h0, 1'b1, mptp_pkg::ST_ENQUEUED, 8'h00, 4'h0);
        add_row(FUNC_ENQ, 8'h00, 4'(mptp_pkg::TOP_LEVEL), 1'b1, mptp_pkg::ST_ENQUEUED,
                8'h00, 4'h0);
        // levels past the top are dropped
        add_row(FUNC_ENQ, 8'h5A, 4'(mptp_pkg::TOP_LEVEL + 1), 1'b1, mptp_pkg::ST_BAD_PRIO,
                8'h00, 4'h0);
        add_row(FUNC_ENQ, 8'hA5, 4'hF, 1'b1, mptp_pkg::ST_BAD_PRIO, 8'h00, 4'h0);
        // level 0 first, then the top level; ignored fields set high
        add_row(FUNC_PICK, 8'hFF, 4'hF, 1'b1, mptp_pkg::ST_PICKED, 8'hFF, 4'h0);
        add_row(FUNC_PICK, 8'hFF, 4'hF, 1'b1, mptp_pkg::ST_PICKED, 8'h00,
                4'(mptp_pkg::TOP_LEVEL));
        add_row(FUNC_PICK, 8'h00, 4'h0, 1'b1, mptp_pkg::ST_NONE, 8'h00, 4'h0);
        // fill one level to the brim, then one more
        for (int k = 0; k < mptp_pkg::QUEUE_DEPTH; k++) begin
            add_row(FUNC_ENQ, 8'($urandom_range(0, 255)), 4'h3, 1'b0,
                    mptp_pkg::ST_ENQUEUED, 8'h00, 4'h0);
        end
        add_row(FUNC_ENQ, 8'h77, 4'h3, 1'b1, mptp_pkg::ST_FULL, 8'h00, 4'h0);

        foreach (stim_rows[r]) begin
            offer_item(stim_rows[r].func, stim_rows[r].id, stim_rows[r].prio,
                       stim_rows[r].fixed, stim_rows[r].want);
        end

        // Random phases; the limit changes only with the block drained.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            write_limit(phase_limits[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // enqueue-heavy stretches fill rings, pick-heavy ones drain them
                if (n % MIX_BLOCK == 0) begin
                    pick = $urandom_range(0, 3);
                    enq_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : (pick == 2) ? 75 : 95;
                end
                // one mid-phase pause until everything is back
                if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                if (burst_left == 0) begin
                    if ($urandom_range(0, 2) != 0) begin
                        idle_cycles($urandom_range(1, 12));
                    end
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;

                f  = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_PICK;
                id = 8'($urandom_range(0, 255));
                // mostly a few busy levels so rings fill, some spread, some illegal
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    p = 4'($urandom_range(0, 2));
                end else if (pick < 85) begin
                    p = 4'($urandom_range(0, mptp_pkg::TOP_LEVEL));
                end else begin
                    p = 4'($urandom_range(mptp_pkg::TOP_LEVEL + 1, 15));
                end
                offer_item(f, id, p, 1'b0, no_want);
            end
        end

        wait_drained();
        if (awaited_results.size() != 0) begin
            report_mismatch("results never delivered", 0, awaited_results.size());
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mptp_pkg.sv
sv/mptp_front.sv
sv/mptp_cmdq.sv
sv/mptp_back.sv
sv/multilevel_priority_task_picker_core.sv
sv/mptp_chk.sv
verif/testbench.sv
